[hw/rtl/assert_macros.svh]
// Assertion macros used by the top level of the digital input edge counter block.
// Depends on nothing; simulation builds get checks, synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/dic_pkg.sv]
// Package for the digital input edge counter block: field widths, action codes,
// parameter defaults and the registered request type. Depends on nothing.
package dic_pkg;

   localparam int ACTION_W = 3;
   localparam int PINS_W   = 8;
   localparam int INDEX_W  = 3;
   localparam int VALUE_W  = 64;
   localparam int LEVEL_W  = 8;
   localparam int DRIVE_W  = 8;
   localparam int READ_W   = 64;

   localparam int DEF_CHANNELS    = 8;
   localparam int DEF_COUNT_WIDTH = 64;

   localparam logic [ACTION_W-1:0] ACT_COUNT_TICK  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_POLL_TICK   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_WRITE_COUNT = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_READ_COUNT  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR_EDGE  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_SET_OUTPUTS = 3'd5;

   typedef struct packed {
      logic                valid;
      logic [ACTION_W-1:0] action;
      logic [PINS_W-1:0]   pins;
      logic [INDEX_W-1:0]  index;
      logic [VALUE_W-1:0]  value;
   } dic_req_type;

endpackage

[hw/rtl/dic_input_reg.sv]
// Input register stage: captures one request per accepted transfer.
// Depends on dic_pkg for the request type.
module dic_input_reg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [dic_pkg::ACTION_W-1:0]        action,
   input  logic [dic_pkg::PINS_W-1:0]          pins,
   input  logic [dic_pkg::INDEX_W-1:0]         index,
   input  logic [dic_pkg::VALUE_W-1:0]         value,
   output dic_pkg::dic_req_type                req
);

   logic                         valid_ff;
   logic                         valid_in;
   logic [dic_pkg::ACTION_W-1:0] action_ff;
   logic [dic_pkg::PINS_W-1:0]   pins_ff;
   logic [dic_pkg::INDEX_W-1:0]  index_ff;
   logic [dic_pkg::VALUE_W-1:0]  value_ff;

   assign valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= action;
         pins_ff   <= pins;
         index_ff  <= index;
         value_ff  <= value;
      end
   end

   always_comb begin
      req.valid  = valid_ff;
      req.action = action_ff;
      req.pins   = pins_ff;
      req.index  = index_ff;
      req.value  = value_ff;
   end

endmodule

[hw/rtl/dic_level_ctl.sv]
// Level state: count-tick previous levels, poll levels, sticky edge latch and
// output drive register. Depends on dic_pkg for widths, codes and the request type.
module dic_level_ctl #(
   parameter int CHANNELS = dic_pkg::DEF_CHANNELS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dic_pkg::dic_req_type          req,
   output logic [CHANNELS-1:0]           rise,
   output logic [dic_pkg::LEVEL_W-1:0]   polled_next,
   output logic [dic_pkg::LEVEL_W-1:0]   edge_next,
   output logic [dic_pkg::DRIVE_W-1:0]   drive_next
);

   logic [CHANNELS-1:0]         lv;
   logic [CHANNELS-1:0]         count_prev_ff, count_prev_in;
   logic [CHANNELS-1:0]         button_ff, button_in;
   logic [CHANNELS-1:0]         edge_ff, edge_in;
   logic [CHANNELS-1:0]         polled_ff, polled_in;
   logic [dic_pkg::DRIVE_W-1:0] drive_ff, drive_in;

   // Pins are active low; channels beyond the pin field never go active.
   for (genvar g = 0; g < CHANNELS; g++) begin : g_lv
      if (g < dic_pkg::PINS_W) begin : g_pin
         assign lv[g] = ~req.pins[g];
      end else begin : g_none
         assign lv[g] = 1'b0;
      end
   end

   assign rise = lv & ~count_prev_ff;

   always_comb begin
      count_prev_in = count_prev_ff;
      button_in     = button_ff;
      edge_in       = edge_ff;
      polled_in     = polled_ff;
      drive_in      = drive_ff;
      if (req.valid) begin
         unique case (req.action)
            dic_pkg::ACT_COUNT_TICK: begin
               count_prev_in = lv;
            end
            dic_pkg::ACT_POLL_TICK: begin
               polled_in = lv;
               edge_in   = edge_ff | (lv & ~button_ff);
               button_in = lv;
            end
            dic_pkg::ACT_CLEAR_EDGE: begin
               edge_in = '0;
            end
            dic_pkg::ACT_SET_OUTPUTS: begin
               drive_in = req.value[dic_pkg::DRIVE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_prev_ff <= '0;
         button_ff     <= '0;
         edge_ff       <= '0;
         polled_ff     <= '0;
         drive_ff      <= '0;
      end else begin
         count_prev_ff <= count_prev_in;
         button_ff     <= button_in;
         edge_ff       <= edge_in;
         polled_ff     <= polled_in;
         drive_ff      <= drive_in;
      end
   end

   assign polled_next = dic_pkg::LEVEL_W'(polled_in);
   assign edge_next   = dic_pkg::LEVEL_W'(edge_in);
   assign drive_next  = drive_in;

endmodule

[hw/rtl/dic_counter_bank.sv]
// Bank of wrapping pulse counters, one per channel, with indexed write and read.
// Depends on dic_pkg for widths, codes and the request type.
module dic_counter_bank #(
   parameter int CHANNELS    = dic_pkg::DEF_CHANNELS,
   parameter int COUNT_WIDTH = dic_pkg::DEF_COUNT_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dic_pkg::dic_req_type         req,
   input  logic [CHANNELS-1:0]          rise,
   output logic [dic_pkg::READ_W-1:0]   read_data
);

   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int IDX_EXT_W = 6;

   logic [COUNT_WIDTH-1:0] counts_ff [CHANNELS];
   logic [COUNT_WIDTH-1:0] counts_in [CHANNELS];
   logic [IDX_EXT_W-1:0]   idx_ext;
   logic [CH_IDX_W-1:0]    sel;
   logic                   in_range;
   logic                   do_count;
   logic                   do_write;
   logic                   do_read;

   assign idx_ext  = IDX_EXT_W'(req.index);
   assign sel      = idx_ext[CH_IDX_W-1:0];
   assign in_range = idx_ext < IDX_EXT_W'(CHANNELS);
   assign do_count = req.valid && (req.action == dic_pkg::ACT_COUNT_TICK);
   assign do_write = req.valid && (req.action == dic_pkg::ACT_WRITE_COUNT) && in_range;
   assign do_read  = req.valid && (req.action == dic_pkg::ACT_READ_COUNT) && in_range;

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         counts_in[ch] = counts_ff[ch];
         if (do_count && rise[ch]) begin
            counts_in[ch] = counts_ff[ch] + COUNT_WIDTH'(1);
         end else if (do_write && (sel == CH_IDX_W'(ch))) begin
            counts_in[ch] = req.value[COUNT_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            counts_ff[ch] <= '0;
         end
      end else begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            counts_ff[ch] <= counts_in[ch];
         end
      end
   end

   // A read never changes a counter, so the current value is the post-update value.
   assign read_data = do_read ? dic_pkg::READ_W'(counts_ff[sel]) : '0;

endmodule

[hw/rtl/digital_input_edge_counters_unit.sv]
// Top level of the digital input edge counter block.
// Depends on dic_pkg, assert_macros.svh, dic_input_reg, dic_level_ctl and dic_counter_bank.
//
// Usage:
//   A request is transferred at a rising edge where start is high and busy is low.
//   busy is never raised, so a request may be issued in every cycle.
//   req_action selects a count tick, poll tick, counter write, counter read,
//   edge-latch clear or output-drive load; req_pins, req_index and req_value
//   carry the operands.
//   Every request produces exactly one response, shown for one cycle with
//   rsp_valid high, after its transfer passes through the input register and
//   then through the state update into the response register.
//   Throughput is one request per clock; the counter bank and the level registers
//   update at the same clock edge that loads the response register.
//   The response reports the state after the request: poll levels, sticky edge
//   latch, drive register, and on a read the selected counter (zero otherwise).
//   Synchronous reset clears all counters, level state, the edge latch, the
//   drive register and any request in flight; no response follows reset.
//   The receiver cannot stall; rsp_valid lasts one cycle and must be taken then.
`include "assert_macros.svh"

module digital_input_edge_counters_unit #(
   parameter int CHANNELS    = dic_pkg::DEF_CHANNELS,
   parameter int COUNT_WIDTH = dic_pkg::DEF_COUNT_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dic_pkg::ACTION_W-1:0]   req_action,
   input  logic [dic_pkg::PINS_W-1:0]     req_pins,
   input  logic [dic_pkg::INDEX_W-1:0]    req_index,
   input  logic [dic_pkg::VALUE_W-1:0]    req_value,
   output logic                           rsp_valid,
   output logic [dic_pkg::LEVEL_W-1:0]    rsp_input_levels,
   output logic [dic_pkg::LEVEL_W-1:0]    rsp_edge_latch,
   output logic [dic_pkg::READ_W-1:0]     rsp_read_count,
   output logic [dic_pkg::DRIVE_W-1:0]    rsp_output_drive
);

   dic_pkg::dic_req_type        req_stage;
   logic [CHANNELS-1:0]         rise;
   logic [dic_pkg::LEVEL_W-1:0] polled_next;
   logic [dic_pkg::LEVEL_W-1:0] edge_next;
   logic [dic_pkg::DRIVE_W-1:0] drive_next;
   logic [dic_pkg::READ_W-1:0]  read_data;

   logic                        rsp_valid_ff;
   logic [dic_pkg::LEVEL_W-1:0] rsp_levels_ff;
   logic [dic_pkg::LEVEL_W-1:0] rsp_edge_ff;
   logic [dic_pkg::READ_W-1:0]  rsp_read_ff;
   logic [dic_pkg::DRIVE_W-1:0] rsp_drive_ff;

   assign busy = 1'b0;

   dic_input_reg u_input_reg (
      .clock  (clock),
      .reset  (reset),
      .accept (start && !busy),
      .action (req_action),
      .pins   (req_pins),
      .index  (req_index),
      .value  (req_value),
      .req    (req_stage)
   );

   dic_level_ctl #(
      .CHANNELS (CHANNELS)
   ) u_level_ctl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_stage),
      .rise        (rise),
      .polled_next (polled_next),
      .edge_next   (edge_next),
      .drive_next  (drive_next)
   );

   dic_counter_bank #(
      .CHANNELS    (CHANNELS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_counter_bank (
      .clock     (clock),
      .reset     (reset),
      .req       (req_stage),
      .rise      (rise),
      .read_data (read_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_stage.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_stage.valid) begin
         rsp_levels_ff <= polled_next;
         rsp_edge_ff   <= edge_next;
         rsp_read_ff   <= read_data;
         rsp_drive_ff  <= drive_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_input_levels = rsp_levels_ff;
   assign rsp_edge_latch   = rsp_edge_ff;
   assign rsp_read_count   = rsp_read_ff;
   assign rsp_output_drive = rsp_drive_ff;

   `ASSERT_NEXT(a_accept_to_stage, clock, reset, start && !busy, req_stage.valid)
   `ASSERT_NEXT(a_stage_to_rsp, clock, reset, req_stage.valid, rsp_valid_ff)
   `ASSERT_NEXT(a_clear_edge, clock, reset, req_stage.valid && (req_stage.action == dic_pkg::ACT_CLEAR_EDGE), rsp_edge_latch == '0)
   `ASSERT_NEXT(a_set_drive, clock, reset, req_stage.valid && (req_stage.action == dic_pkg::ACT_SET_OUTPUTS), rsp_output_drive == $past(req_stage.value[dic_pkg::DRIVE_W-1:0]))

endmodule

[tb/sv/dic_status_monitor.sv]
// Checker for the digital input edge counter block: watches request and response ports,
// keeps its own copy of the counters and level state, and compares every response.
// Depends on dic_pkg for field widths and action codes.
`timescale 1ns / 1ps

module dic_status_monitor
   import dic_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [PINS_W-1:0]   req_pins,
   input  logic [INDEX_W-1:0]  req_index,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic                rsp_valid,
   input  logic [LEVEL_W-1:0]  rsp_input_levels,
   input  logic [LEVEL_W-1:0]  rsp_edge_latch,
   input  logic [READ_W-1:0]   rsp_read_count,
   input  logic [DRIVE_W-1:0]  rsp_output_drive,
   output int                  mismatches,
   output int                  outstanding,
   output int                  compared
);

   localparam int CHANNELS = DEF_CHANNELS;

   typedef struct {
      logic [LEVEL_W-1:0] levels;
      logic [LEVEL_W-1:0] latch;
      logic [READ_W-1:0]  count;
      logic [DRIVE_W-1:0] drive;
   } status_word_type;

   logic [DEF_COUNT_WIDTH-1:0] pulse_count [CHANNELS];
   logic [CHANNELS-1:0]        tick_levels;
   logic [CHANNELS-1:0]        button_state;
   logic [CHANNELS-1:0]        latch_bits;
   logic [CHANNELS-1:0]        poll_levels;
   logic [DRIVE_W-1:0]         drive_reg;

   status_word_type awaited_status [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
      compared    = 0;
   end

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Applies one request to the local state and returns the status it should report.
   function automatic status_word_type apply_request(input logic [ACTION_W-1:0] act,
                                                     input logic [PINS_W-1:0] pins,
                                                     input logic [INDEX_W-1:0] idx,
                                                     input logic [VALUE_W-1:0] val);
      status_word_type     word;
      logic [CHANNELS-1:0] active;
      logic [CHANNELS-1:0] rose;
      logic [READ_W-1:0]   readback;
      readback = '0;
      // Pins are active low.
      active = ~pins[CHANNELS-1:0];
      case (act)
         ACT_COUNT_TICK: begin
            rose = active & ~tick_levels;
            for (int ch = 0; ch < CHANNELS; ch++)
               if (rose[ch]) pulse_count[ch] = pulse_count[ch] + 1'b1;
            tick_levels = active;
         end
         ACT_POLL_TICK: begin
            poll_levels  = active;
            latch_bits   = latch_bits | (active & ~button_state);
            button_state = active;
         end
         ACT_WRITE_COUNT: begin
            if (idx < CHANNELS) pulse_count[idx] = val[DEF_COUNT_WIDTH-1:0];
         end
         ACT_READ_COUNT: begin
            if (idx < CHANNELS) readback = pulse_count[idx];
         end
         ACT_CLEAR_EDGE: latch_bits = '0;
         ACT_SET_OUTPUTS: drive_reg = val[DRIVE_W-1:0];
         default: ;
      endcase
      word.levels = poll_levels;
      word.latch  = latch_bits;
      word.count  = readback;
      word.drive  = drive_reg;
      return word;
   endfunction

   always @(posedge clock) begin
      status_word_type want;
      if (reset) begin
         for (int ch = 0; ch < CHANNELS; ch++) pulse_count[ch] = '0;
         tick_levels  = '0;
         button_state = '0;
         latch_bits   = '0;
         poll_levels  = '0;
         drive_reg    = '0;
         awaited_status.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (awaited_status.size() == 0) begin
               flag_mismatch("response with nothing outstanding", rsp_read_count, '0);
            end else begin
               want = awaited_status.pop_front();
               compared++;
               if (rsp_input_levels !== want.levels)
                  flag_mismatch("input_levels", rsp_input_levels, want.levels);
               if (rsp_edge_latch !== want.latch)
                  flag_mismatch("edge_latch", rsp_edge_latch, want.latch);
               if (rsp_read_count !== want.count)
                  flag_mismatch("read_count", rsp_read_count, want.count);
               if (rsp_output_drive !== want.drive)
                  flag_mismatch("output_drive", rsp_output_drive, want.drive);
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            awaited_status.push_back(apply_request(req_action, req_pins, req_index,
                                                   req_value));
      end
      outstanding = awaited_status.size();
   end

endmodule

[tb/sv/digital_input_edge_counters_unit_tb.sv]
// Testbench top for the digital input edge counter block: clock, reset and request stimulus.
// Depends on dic_pkg, digital_input_edge_counters_unit and the dic_status_monitor checker.
`timescale 1ns / 1ps

module digital_input_edge_counters_unit_tb;
   import dic_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 6;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [ACTION_W-1:0] req_action;
   logic [PINS_W-1:0]   req_pins;
   logic [INDEX_W-1:0]  req_index;
   logic [VALUE_W-1:0]  req_value;
   logic                rsp_valid;
   logic [LEVEL_W-1:0]  rsp_input_levels;
   logic [LEVEL_W-1:0]  rsp_edge_latch;
   logic [READ_W-1:0]   rsp_read_count;
   logic [DRIVE_W-1:0]  rsp_output_drive;

   int mismatches;
   int outstanding;
   int compared;
   int cycle_count = 0;
   int per_action [8];
   bit gaps_allowed = 1'b1;
   logic [PINS_W-1:0] last_pins = '1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   digital_input_edge_counters_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_pins         (req_pins),
      .req_index        (req_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_input_levels (rsp_input_levels),
      .rsp_edge_latch   (rsp_edge_latch),
      .rsp_read_count   (rsp_read_count),
      .rsp_output_drive (rsp_output_drive)
   );

   dic_status_monitor u_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_pins         (req_pins),
      .req_index        (req_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_input_levels (rsp_input_levels),
      .rsp_edge_latch   (rsp_edge_latch),
      .rsp_read_count   (rsp_read_count),
      .rsp_output_drive (rsp_output_drive),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .compared         (compared)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Presents one request and holds it until the transfer takes place.
   task automatic issue(input logic [ACTION_W-1:0] act, input logic [PINS_W-1:0] pins,
                        input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] val);
      while (gaps_allowed && $urandom_range(99) < 23) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_action <= act;
      req_pins   <= pins;
      req_index  <= idx;
      req_value  <= val;
      per_action[act]++;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   function automatic logic [ACTION_W-1:0] pick_action();
      int roll;
      roll = $urandom_range(99);
      if (roll < 30) return ACT_COUNT_TICK;
      if (roll < 55) return ACT_POLL_TICK;
      if (roll < 66) return ACT_WRITE_COUNT;
      if (roll < 80) return ACT_READ_COUNT;
      if (roll < 86) return ACT_CLEAR_EDGE;
      if (roll < 94) return ACT_SET_OUTPUTS;
      return ($urandom_range(1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
   endfunction

   initial begin
      logic [ACTION_W-1:0] act;
      logic [PINS_W-1:0]   pins;
      logic [VALUE_W-1:0]  val;
      reset      <= 1'b1;
      start      <= 1'b0;
      req_action <= ACT_COUNT_TICK;
      req_pins   <= '1;
      req_index  <= '0;
      req_value  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle pins, all channels rising at once, no rise on a held level,
      // counter wrap from all ones, polls with the sticky latch, drive byte taken
      // from the low bits only, and the two spare action codes.
      issue(ACT_READ_COUNT, 8'h00, 3'd0, '1);
      issue(ACT_COUNT_TICK, 8'hFF, 3'd7, '1);
      issue(ACT_COUNT_TICK, 8'h00, 3'd0, '0);
      issue(ACT_COUNT_TICK, 8'h00, 3'd0, '0);
      issue(ACT_POLL_TICK, 8'h00, 3'd0, '0);
      issue(ACT_POLL_TICK, 8'hFF, 3'd0, '0);
      issue(ACT_POLL_TICK, 8'h5A, 3'd0, '0);
      issue(ACT_CLEAR_EDGE, 8'h00, 3'd0, '1);
      issue(ACT_WRITE_COUNT, 8'h00, 3'd7, '1);
      issue(ACT_COUNT_TICK, 8'hFF, 3'd0, '0);
      issue(ACT_COUNT_TICK, 8'h7F, 3'd0, '0);
      issue(ACT_READ_COUNT, 8'hFF, 3'd7, '0);
      issue(ACT_WRITE_COUNT, 8'h00, 3'd0, 64'h8000_0000_0000_0000);
      issue(ACT_READ_COUNT, 8'h00, 3'd0, '0);
      issue(ACT_SET_OUTPUTS, 8'h00, 3'd0, 64'hFFFF_FFFF_FFFF_FFA5);
      issue(ACT_SET_OUTPUTS, 8'hFF, 3'd7, 64'h0000_0000_0000_0100);
      issue(ACT_SPARE_LO, 8'h00, 3'd3, '1);
      issue(ACT_SPARE_HI, 8'hFF, 3'd4, '1);
      for (int ch = 1; ch < 7; ch++) issue(ACT_READ_COUNT, 8'h00, ch[INDEX_W-1:0], '0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         gaps_allowed = !(n >= 150 && n < 250);
         act = pick_action();
         // Pins are random, inverted or randomly toggled from the last ones so that rises and held levels both occur.
         case ($urandom_range(3))
            0:       pins = PINS_W'($urandom);
            1:       pins = ~last_pins;
            default: pins = last_pins ^ PINS_W'($urandom);
         endcase
         if (act == ACT_COUNT_TICK || act == ACT_POLL_TICK) last_pins = pins;
         val = {$urandom, $urandom};
         // Some writes land at or just below the top so that later ticks wrap the counter.
         if (act == ACT_WRITE_COUNT && $urandom_range(2) == 0)
            val = '1 - VALUE_W'($urandom_range(3));
         issue(act, pins, INDEX_W'($urandom_range(7)), val);
      end
      start <= 1'b0;

      do @(negedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d count ticks, %0d poll ticks, %0d writes, %0d reads, %0d clears,",
               per_action[ACT_COUNT_TICK], per_action[ACT_POLL_TICK],
               per_action[ACT_WRITE_COUNT], per_action[ACT_READ_COUNT],
               per_action[ACT_CLEAR_EDGE]);
      $display("%0d drive loads and %0d spare codes; %0d responses compared, %0d mismatches",
               per_action[ACT_SET_OUTPUTS], per_action[ACT_SPARE_LO] + per_action[ACT_SPARE_HI],
               compared, mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
